FILE: design/refcounted_block_allocator_assert.svh
// Assertion macros used by the checker file of the block allocator.
`ifndef REFCOUNTED_BLOCK_ALLOCATOR_ASSERT_SVH
`define REFCOUNTED_BLOCK_ALLOCATOR_ASSERT_SVH

// Implication in the same cycle, checked outside reset.
`define RCBA_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Implication in the next cycle, checked outside reset.
`define RCBA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: design/rcba_pkg.sv
// Package with the constants, codes and types of the block allocator.
`timescale 1ns / 1ps
package rcba_pkg;
    localparam int BLOCK_TOTAL = 1024;
    localparam int ID_W        = 10;
    localparam int FCNT_W      = $clog2(BLOCK_TOTAL + 1);
    localparam int GEN_W       = 32;
    localparam int CNT_W       = 16;
    localparam int POOL_W      = 16;

    // Operation codes.
    localparam logic [2:0] OP_ALLOC   = 3'd0;
    localparam logic [2:0] OP_INCREF  = 3'd1;
    localparam logic [2:0] OP_FREE    = 3'd2;
    localparam logic [2:0] OP_QUERY   = 3'd3;
    localparam logic [2:0] OP_HANDLE  = 3'd4;
    localparam logic [2:0] OP_CHECK   = 3'd5;
    localparam logic [2:0] OP_ACQUIRE = 3'd6;
    localparam logic [2:0] OP_RELEASE = 3'd7;

    // Status codes.
    localparam logic [2:0] STAT_OK    = 3'd0;
    localparam logic [2:0] STAT_EMPTY = 3'd1;
    localparam logic [2:0] STAT_FREE  = 3'd2;
    localparam logic [2:0] STAT_STALE = 3'd3;
    localparam logic [2:0] STAT_NOPIN = 3'd4;
    localparam logic [2:0] STAT_OVF   = 3'd5;

    // One entry of the per-block table.
    typedef struct packed {
        logic [GEN_W-1:0] gen;
        logic [CNT_W-1:0] cnt;
        logic [CNT_W-1:0] cpin;
        logic [CNT_W-1:0] ipin;
    } entry_t;

    // Requests to the free queue.
    typedef struct packed {
        logic            pop;
        logic            push;
        logic [ID_W-1:0] push_id;
    } fq_req_t;
endpackage

FILE: design/refcounted_block_allocator.sv
// Top level of the reference counted block allocator.
// Usage:
// The input channel (in_valid, in_stall) takes one word per operation: mode,
// sel_block, handle_generation, handle_pool and lease_kind. The output channel
// (out_valid, out_stall) returns exactly one result word per operation.
// The pool tag register is written with cfg_write and cfg_data; the user must
// do so only while idle, as the block does not enforce it. An allocation
// reads the free queue head when it is accepted; every operation reads the
// per-block table entry in the fetch step, and in the execute step updates
// the entry, pushes a freed block and loads the output register. Only one
// operation runs at a time; the next word is taken while a result still waits
// in the output register. After reset the table is cleared by a pass over all
// 1024 entries, one entry per cycle; in_stall stays high during that pass. The
// free queue starts with all blocks in order without a pass.
// When the receiver stalls, the result holds in the output register and the
// block stalls in its final step until the register drains.
`timescale 1ns / 1ps
module refcounted_block_allocator
    import rcba_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_write,
    input  logic [POOL_W-1:0] cfg_data,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [2:0]        mode,
    input  logic [ID_W-1:0]   sel_block,
    input  logic [GEN_W-1:0]  handle_generation,
    input  logic [POOL_W-1:0] handle_pool,
    input  logic              lease_kind,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [2:0]        status,
    output logic [ID_W-1:0]   result_block,
    output logic [GEN_W-1:0]  block_generation,
    output logic [CNT_W-1:0]  use_count,
    output logic [CNT_W-1:0]  compute_pin_count,
    output logic [CNT_W-1:0]  io_pin_count,
    output logic              handle_live
);
    localparam logic [1:0] S_CLEAR = 2'd0;
    localparam logic [1:0] S_IDLE  = 2'd1;
    localparam logic [1:0] S_FETCH = 2'd2;
    localparam logic [1:0] S_EXEC  = 2'd3;

    logic [1:0]        state_reg, state_next;
    logic [ID_W-1:0]   clr_reg;
    logic [POOL_W-1:0] own_pool_reg;

    logic [2:0]        mode_reg;
    logic [ID_W-1:0]   bid_reg;
    logic [GEN_W-1:0]  hgen_reg;
    logic [POOL_W-1:0] hpool_reg;
    logic              kind_reg;
    logic              fail_reg;
    logic [ID_W-1:0]   addr_reg;

    entry_t            tbl [BLOCK_TOTAL];
    entry_t            rd_reg;

    fq_req_t           fq_req;
    logic [ID_W-1:0]   fq_head;
    logic [FCNT_W-1:0] fq_count;

    logic              accept;
    logic              finish;
    logic              tbl_we;
    entry_t            nxt;
    logic [2:0]        stat;
    logic              cur;
    logic [CNT_W-1:0]  pin;
    logic              push_ok;

    logic              out_valid_reg;
    logic [2:0]        status_reg;
    logic [ID_W-1:0]   block_reg;
    entry_t            out_entry_reg;
    logic              cur_out_reg;

    assign accept = in_valid && (state_reg == S_IDLE);
    assign finish = (state_reg == S_EXEC) && (!out_valid_reg || !out_stall);

    // Free queue.
    rcba_free_queue u_fq (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (fq_req),
        .head_id (fq_head),
        .count   (fq_count)
    );

    // Pool tag register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            own_pool_reg <= POOL_W'(1);
        end
        else if (cfg_write)
        begin
            own_pool_reg <= cfg_data;
        end
    end

    // Sequencer state and the clearing counter.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            clr_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_CLEAR)
            begin
                clr_reg <= clr_reg + 1'b1;
            end
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR: if (clr_reg == ID_W'(BLOCK_TOTAL - 1)) state_next = S_IDLE;
            S_IDLE:  if (accept) state_next = S_FETCH;
            S_FETCH: state_next = S_EXEC;
            S_EXEC:  if (finish) state_next = S_IDLE;
            default: state_next = S_CLEAR;
        endcase
    end

    // Capture of the input word.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            mode_reg  <= mode;
            bid_reg   <= sel_block;
            hgen_reg  <= handle_generation;
            hpool_reg <= handle_pool;
            kind_reg  <= lease_kind;
            fail_reg  <= (fq_count == '0);
        end
        if (state_reg == S_FETCH)
        begin
            addr_reg <= (mode_reg == OP_ALLOC) ? fq_head : bid_reg;
        end
    end

    // Table memory: registered read in the fetch step, write on clear or update.
    always_ff @(posedge clk)
    begin
        if (state_reg == S_CLEAR)
        begin
            tbl[clr_reg] <= '0;
        end
        else if (tbl_we)
        begin
            tbl[addr_reg] <= nxt;
        end
        if (state_reg == S_FETCH)
        begin
            rd_reg <= tbl[(mode_reg == OP_ALLOC) ? fq_head : bid_reg];
        end
    end

    // Update of the addressed entry.
    always_comb
    begin
        nxt     = rd_reg;
        stat    = STAT_OK;
        tbl_we  = 1'b0;
        cur     = (mode_reg[2] == 1'b1) && (hpool_reg == own_pool_reg)
                  && (rd_reg.cnt != '0) && (rd_reg.gen == hgen_reg);
        pin     = kind_reg ? rd_reg.ipin : rd_reg.cpin;
        push_ok = (rd_reg.gen != '1) && (fq_count < FCNT_W'(BLOCK_TOTAL));
        fq_req  = '{pop: accept && (mode == OP_ALLOC) && (fq_count != '0),
                    push: 1'b0, push_id: addr_reg};
        unique case (mode_reg)
            OP_ALLOC:
            begin
                if (fail_reg)
                begin
                    stat = STAT_EMPTY;
                end
                else
                begin
                    nxt.gen = rd_reg.gen + GEN_W'(rd_reg.gen != '1);
                    nxt.cnt = CNT_W'(1);
                    tbl_we  = finish;
                end
            end
            OP_INCREF:
            begin
                if (rd_reg.cnt == '0) stat = STAT_FREE;
                else if (rd_reg.cnt == '1) stat = STAT_OVF;
                else
                begin
                    nxt.cnt = rd_reg.cnt + 1'b1;
                    tbl_we  = finish;
                end
            end
            OP_FREE:
            begin
                if (rd_reg.cnt == '0) stat = STAT_FREE;
                else
                begin
                    nxt.cnt     = rd_reg.cnt - 1'b1;
                    tbl_we      = finish;
                    fq_req.push = finish && (rd_reg.cnt == CNT_W'(1)) && push_ok;
                end
            end
            OP_QUERY: stat = STAT_OK;
            OP_HANDLE: stat = (rd_reg.cnt == '0) ? STAT_FREE : STAT_OK;
            OP_CHECK: stat = STAT_OK;
            OP_ACQUIRE:
            begin
                if (!cur) stat = STAT_STALE;
                else if ((rd_reg.cnt == '1) || (pin == '1)) stat = STAT_OVF;
                else
                begin
                    nxt.cnt = rd_reg.cnt + 1'b1;
                    if (kind_reg) nxt.ipin = rd_reg.ipin + 1'b1;
                    else nxt.cpin = rd_reg.cpin + 1'b1;
                    tbl_we = finish;
                end
            end
            OP_RELEASE:
            begin
                if (!cur) stat = STAT_STALE;
                else if (pin == '0) stat = STAT_NOPIN;
                else
                begin
                    nxt.cnt = rd_reg.cnt - 1'b1;
                    if (kind_reg) nxt.ipin = rd_reg.ipin - 1'b1;
                    else nxt.cpin = rd_reg.cpin - 1'b1;
                    tbl_we      = finish;
                    fq_req.push = finish && (rd_reg.cnt == CNT_W'(1)) && push_ok;
                end
            end
            default: stat = STAT_OK;
        endcase
    end

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (finish)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (finish)
        begin
            status_reg <= stat;
            if ((mode_reg == OP_ALLOC) && fail_reg)
            begin
                block_reg     <= '0;
                out_entry_reg <= '0;
            end
            else
            begin
                block_reg     <= addr_reg;
                out_entry_reg <= nxt;
            end
            cur_out_reg <= cur;
        end
    end

    assign in_stall          = (state_reg != S_IDLE);
    assign out_valid         = out_valid_reg;
    assign status            = status_reg;
    assign result_block      = block_reg;
    assign block_generation  = out_entry_reg.gen;
    assign use_count         = out_entry_reg.cnt;
    assign compute_pin_count = out_entry_reg.cpin;
    assign io_pin_count      = out_entry_reg.ipin;
    assign handle_live       = cur_out_reg;
endmodule

FILE: design/rcba_free_queue.sv
// Free queue of block identifiers held in a synchronous memory.
`timescale 1ns / 1ps
module rcba_free_queue
    import rcba_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  fq_req_t           req,
    output logic [ID_W-1:0]   head_id,
    output logic [FCNT_W-1:0] count
);
    logic [ID_W-1:0]   mem [BLOCK_TOTAL];
    logic [ID_W-1:0]   rd_reg;
    logic [ID_W-1:0]   ident_reg;
    logic              use_mem_reg;
    logic [ID_W-1:0]   head_reg;
    logic [ID_W-1:0]   tail_reg;
    logic              wrapped_reg;
    logic [FCNT_W-1:0] count_reg;

    // Memory port: write on push, registered read on pop.
    always_ff @(posedge clk)
    begin
        if (req.push)
        begin
            mem[tail_reg] <= req.push_id;
        end
        if (req.pop)
        begin
            rd_reg    <= mem[head_reg];
            ident_reg <= head_reg;
        end
    end

    // Pointers and fill count; a slot not yet written holds its own index.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg    <= '0;
            tail_reg    <= '0;
            wrapped_reg <= 1'b0;
            use_mem_reg <= 1'b0;
            count_reg   <= FCNT_W'(BLOCK_TOTAL);
        end
        else
        begin
            if (req.pop)
            begin
                use_mem_reg <= wrapped_reg || (head_reg < tail_reg);
                head_reg    <= head_reg + 1'b1;
                count_reg   <= count_reg - 1'b1;
            end
            else if (req.push)
            begin
                tail_reg  <= tail_reg + 1'b1;
                count_reg <= count_reg + 1'b1;
                if (tail_reg == ID_W'(BLOCK_TOTAL - 1))
                begin
                    wrapped_reg <= 1'b1;
                end
            end
        end
    end

    assign head_id = use_mem_reg ? rd_reg : ident_reg;
    assign count   = count_reg;
endmodule

FILE: design/rcba_checker.sv
// Port-level checker of the block allocator and its bind.
`timescale 1ns / 1ps
`include "refcounted_block_allocator_assert.svh"
module rcba_checker
    import rcba_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              in_valid,
    input logic              in_stall,
    input logic              out_valid,
    input logic              out_stall,
    input logic [2:0]        status,
    input logic [ID_W-1:0]   result_block,
    input logic [CNT_W-1:0]  use_count,
    input logic              handle_live
);
    // A stalled result word stays offered.
    `RCBA_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid, "result word dropped")
    // An accepted operation keeps the input busy in the next cycle.
    `RCBA_ASSERT_NEXT(a_busy, in_valid && !in_stall, in_stall, "input taken twice")
    // A failed allocation reports an empty result.
    `RCBA_ASSERT_SAME(a_empty, out_valid && (status == STAT_EMPTY),
        (use_count == '0) && (result_block == '0), "failed allocation not zeroed")
    // A current handle never sees a free or stale status.
    `RCBA_ASSERT_SAME(a_cur, out_valid && handle_live,
        (status != STAT_FREE) && (status != STAT_STALE), "current handle rejected")
endmodule

bind refcounted_block_allocator rcba_checker u_rcba_checker (.*);

FILE: test/refcounted_block_allocator_test.sv
// Self-checking testbench for the reference counted block allocator.
`timescale 1ns / 1ps
module refcounted_block_allocator_test;
    import rcba_pkg::*;

    localparam logic [CNT_W-1:0] CNT_MAX = '1;
    localparam logic [GEN_W-1:0] GEN_MAX = '1;
    localparam int IDLE_LIMIT = 20000;
    localparam int HOLD_CYCLES = 400;

    // One operation word and one result word.
    typedef struct {
        logic [2:0]        op;
        logic [ID_W-1:0]   id;
        logic [GEN_W-1:0]  hgen;
        logic [POOL_W-1:0] hpool;
        logic              kind;
    } op_word_t;

    typedef struct {
        logic [2:0]        stat;
        logic [ID_W-1:0]   blk;
        logic [GEN_W-1:0]  gen;
        logic [CNT_W-1:0]  cnt;
        logic [CNT_W-1:0]  cpin;
        logic [CNT_W-1:0]  ipin;
        logic              cur;
    } result_word_t;

    logic clk;
    logic rst_n;
    logic cfg_write;
    logic [POOL_W-1:0] cfg_data;
    logic in_valid;
    logic in_stall;
    logic [2:0] mode;
    logic [ID_W-1:0] sel_block;
    logic [GEN_W-1:0] handle_generation;
    logic [POOL_W-1:0] handle_pool;
    logic lease_kind;
    logic out_valid;
    logic out_stall;
    logic [2:0] status;
    logic [ID_W-1:0] result_block;
    logic [GEN_W-1:0] block_generation;
    logic [CNT_W-1:0] use_count;
    logic [CNT_W-1:0] compute_pin_count;
    logic [CNT_W-1:0] io_pin_count;
    logic handle_live;

    refcounted_block_allocator u_top (
        .clk(clk), .rst_n(rst_n), .cfg_write(cfg_write), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_stall(in_stall), .mode(mode), .sel_block(sel_block),
        .handle_generation(handle_generation), .handle_pool(handle_pool),
        .lease_kind(lease_kind), .out_valid(out_valid), .out_stall(out_stall),
        .status(status), .result_block(result_block),
        .block_generation(block_generation), .use_count(use_count),
        .compute_pin_count(compute_pin_count), .io_pin_count(io_pin_count),
        .handle_live(handle_live)
    );

    // Shadow state of the allocator.
    logic [ID_W-1:0]   sh_fifo [BLOCK_TOTAL];
    int                sh_head;
    int                sh_tail;
    int                sh_free;
    logic [CNT_W-1:0]  sh_cnt  [BLOCK_TOTAL];
    logic [GEN_W-1:0]  sh_gen  [BLOCK_TOTAL];
    logic [CNT_W-1:0]  sh_cpin [BLOCK_TOTAL];
    logic [CNT_W-1:0]  sh_ipin [BLOCK_TOTAL];
    logic [POOL_W-1:0] sh_pool;

    op_word_t     pending_ops[$];
    result_word_t expected_results[$];
    int           live_ids[$];
    int           failures = 0;
    int           words_checked = 0;
    int           status_seen [8] = '{default: 0};
    int           idle_cycles;
    logic         no_idle;
    logic         hold_go;
    int           hold_left;

    // Drop one reference and requeue the block when it becomes free.
    function automatic logic [2:0] release_ref(input int b);
        if (sh_cnt[b] == 0)
            return STAT_FREE;
        sh_cnt[b] = sh_cnt[b] - 1'b1;
        if (sh_cnt[b] == 0 && sh_gen[b] != GEN_MAX && sh_free < BLOCK_TOTAL)
        begin
            sh_fifo[sh_tail] = b[ID_W-1:0];
            sh_tail = (sh_tail + 1) % BLOCK_TOTAL;
            sh_free++;
        end
        return STAT_OK;
    endfunction

    // Compute the result of one operation and advance the shadow state.
    function automatic result_word_t allocator_step(input op_word_t w);
        result_word_t r;
        int b;
        logic cur;
        logic [2:0] st;
        logic [CNT_W-1:0] pin;
        b = int'(w.id);
        st = STAT_OK;
        cur = (w.op >= OP_HANDLE) && w.hpool == sh_pool && sh_cnt[b] > 0
            && sh_gen[b] == w.hgen;
        if (w.op == OP_ALLOC)
        begin
            if (sh_free == 0)
            begin
                r = '{STAT_EMPTY, '0, '0, '0, '0, '0, 1'b0};
                return r;
            end
            b = int'(sh_fifo[sh_head]);
            sh_head = (sh_head + 1) % BLOCK_TOTAL;
            sh_free--;
            if (sh_gen[b] != GEN_MAX)
                sh_gen[b] = sh_gen[b] + 1'b1;
            sh_cnt[b] = CNT_W'(1);
            cur = 1'b0;
        end
        else
        begin
            pin = w.kind ? sh_ipin[b] : sh_cpin[b];
            case (w.op)
                OP_INCREF:
                begin
                    if (sh_cnt[b] == 0)
                        st = STAT_FREE;
                    else if (sh_cnt[b] == CNT_MAX)
                        st = STAT_OVF;
                    else
                        sh_cnt[b] = sh_cnt[b] + 1'b1;
                end
                OP_FREE:
                    st = release_ref(b);
                OP_QUERY:
                    st = STAT_OK;
                OP_HANDLE:
                    st = (sh_cnt[b] > 0) ? STAT_OK : STAT_FREE;
                OP_CHECK:
                    st = STAT_OK;
                OP_ACQUIRE:
                begin
                    if (!cur)
                        st = STAT_STALE;
                    else if (sh_cnt[b] == CNT_MAX || pin == CNT_MAX)
                        st = STAT_OVF;
                    else
                    begin
                        sh_cnt[b] = sh_cnt[b] + 1'b1;
                        if (w.kind)
                            sh_ipin[b] = pin + 1'b1;
                        else
                            sh_cpin[b] = pin + 1'b1;
                    end
                end
                default:
                begin
                    if (!cur)
                        st = STAT_STALE;
                    else if (pin == 0)
                        st = STAT_NOPIN;
                    else
                    begin
                        if (w.kind)
                            sh_ipin[b] = pin - 1'b1;
                        else
                            sh_cpin[b] = pin - 1'b1;
                        st = release_ref(b);
                    end
                end
            endcase
        end
        r = '{st, b[ID_W-1:0], sh_gen[b], sh_cnt[b], sh_cpin[b], sh_ipin[b], cur};
        return r;
    endfunction

    // Queue one operation with its predicted result and track live blocks.
    task automatic issue(input logic [2:0] op, input int id, input logic [GEN_W-1:0] hgen,
                         input logic [POOL_W-1:0] hpool, input logic kind);
        op_word_t w;
        result_word_t r;
        int k;
        w = '{op, id[ID_W-1:0], hgen, hpool, kind};
        r = allocator_step(w);
        pending_ops.push_back(w);
        expected_results.push_back(r);
        if (op == OP_ALLOC && r.stat == STAT_OK)
            live_ids.push_back(int'(r.blk));
        if (sh_cnt[r.blk] == 0)
        begin
            for (k = live_ids.size() - 1; k >= 0; k--)
                if (live_ids[k] == int'(r.blk))
                    live_ids.delete(k);
        end
    endtask

    // Operation on a block addressed through a correct handle.
    task automatic issue_good(input logic [2:0] op, input int id, input logic kind);
        issue(op, id, sh_gen[id], sh_pool, kind);
    endtask

    // Wait until every result is back, then let the pipeline settle.
    task automatic drain();
        while (pending_ops.size() > 0 || expected_results.size() > 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
    endtask

    // Write the pool tag register while the block is idle.
    task automatic write_pool(input logic [POOL_W-1:0] v);
        drain();
        cfg_write <= 1'b1;
        cfg_data <= v;
        @(posedge clk);
        cfg_write <= 1'b0;
        sh_pool = v;
    endtask

    // Random operation: mostly well-formed on live blocks, some noise.
    task automatic issue_random();
        int r;
        int id;
        logic [2:0] op;
        r = $urandom_range(99);
        if (r < 8)
            issue(3'($urandom_range(7)), $urandom_range(BLOCK_TOTAL - 1), $urandom(),
                  POOL_W'($urandom()), 1'($urandom_range(1)));
        else if (live_ids.size() == 0 || r < 22 || (live_ids.size() < 4 && r < 40))
            issue(OP_ALLOC, $urandom_range(BLOCK_TOTAL - 1), $urandom(),
                  POOL_W'($urandom()), 1'($urandom_range(1)));
        else
        begin
            id = live_ids[$urandom_range(live_ids.size() - 1)];
            op = 3'($urandom_range(7, 1));
            if (live_ids.size() > 40 && $urandom_range(3) == 0)
                op = OP_FREE;
            if ($urandom_range(9) == 0)
                issue(op, id, $urandom(), sh_pool, 1'($urandom_range(1)));
            else if ($urandom_range(19) == 0)
                issue(op, id, sh_gen[id], POOL_W'($urandom()), 1'($urandom_range(1)));
            else
                issue_good(op, id, 1'($urandom_range(1)));
        end
    endtask

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Driver: present queued words, idling at random.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            mode <= '0;
            sel_block <= '0;
            handle_generation <= '0;
            handle_pool <= '0;
            lease_kind <= 1'b0;
        end
        else if (!in_valid || !in_stall)
        begin
            if (pending_ops.size() > 0 && (no_idle || $urandom_range(99) >= 33))
            begin
                mode <= pending_ops[0].op;
                sel_block <= pending_ops[0].id;
                handle_generation <= pending_ops[0].hgen;
                handle_pool <= pending_ops[0].hpool;
                lease_kind <= pending_ops[0].kind;
                in_valid <= 1'b1;
                pending_ops.pop_front();
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // Monitor: stall at random or for a long hold-off, check each result word.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            hold_left <= 0;
            idle_cycles <= 0;
        end
        else
        begin
            if (hold_go && hold_left == 0)
            begin
                hold_left <= HOLD_CYCLES;
                out_stall <= 1'b1;
            end
            else if (hold_left > 1)
            begin
                hold_left <= hold_left - 1;
                out_stall <= 1'b1;
            end
            else
            begin
                if (hold_left == 1)
                    hold_left <= 0;
                out_stall <= !no_idle && $urandom_range(99) < 33;
            end

            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;

            if (out_valid && !out_stall)
            begin
                if (expected_results.size() == 0)
                begin
                    $error("result word with nothing expected");
                    failures++;
                end
                else
                begin
                    if (status !== expected_results[0].stat)
                    begin
                        $error("status: expected %0d, got %0d",
                               expected_results[0].stat, status);
                        failures++;
                    end
                    if (result_block !== expected_results[0].blk)
                    begin
                        $error("result_block: expected %0d, got %0d",
                               expected_results[0].blk, result_block);
                        failures++;
                    end
                    if (block_generation !== expected_results[0].gen)
                    begin
                        $error("block_generation: expected %0d, got %0d",
                               expected_results[0].gen, block_generation);
                        failures++;
                    end
                    if (use_count !== expected_results[0].cnt)
                    begin
                        $error("use_count: expected %0d, got %0d",
                               expected_results[0].cnt, use_count);
                        failures++;
                    end
                    if (compute_pin_count !== expected_results[0].cpin)
                    begin
                        $error("compute_pin_count: expected %0d, got %0d",
                               expected_results[0].cpin, compute_pin_count);
                        failures++;
                    end
                    if (io_pin_count !== expected_results[0].ipin)
                    begin
                        $error("io_pin_count: expected %0d, got %0d",
                               expected_results[0].ipin, io_pin_count);
                        failures++;
                    end
                    if (handle_live !== expected_results[0].cur)
                    begin
                        $error("handle_live: expected %0d, got %0d",
                               expected_results[0].cur, handle_live);
                        failures++;
                    end
                    status_seen[expected_results[0].stat]++;
                    words_checked++;
                    expected_results.pop_front();
                end
            end
        end
    end

    // Watchdog on cycles with no word moving on either channel.
    always @(posedge clk)
    begin
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Stimulus sequence and final verdict.
    initial
    begin
        int i;
        int p;
        int a;
        int b;
        logic [POOL_W-1:0] pools [5];
        rst_n = 1'b0;
        cfg_write = 1'b0;
        cfg_data = '0;
        no_idle = 1'b0;
        hold_go = 1'b0;
        for (i = 0; i < BLOCK_TOTAL; i++)
        begin
            sh_fifo[i] = i[ID_W-1:0];
            sh_cnt[i] = '0;
            sh_gen[i] = '0;
            sh_cpin[i] = '0;
            sh_ipin[i] = '0;
        end
        sh_head = 0;
        sh_tail = 0;
        sh_free = BLOCK_TOTAL;
        sh_pool = POOL_W'(1);
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part under the reset pool tag.
        issue(OP_ALLOC, 0, 0, 0, 0);
        issue(OP_ALLOC, BLOCK_TOTAL - 1, GEN_MAX, '1, 1);
        a = 0;
        b = 1;
        issue_good(OP_INCREF, a, 0);
        issue_good(OP_QUERY, a, 0);
        issue_good(OP_HANDLE, a, 0);
        issue_good(OP_CHECK, a, 0);
        issue(OP_CHECK, a, GEN_MAX, sh_pool, 0);
        issue(OP_CHECK, a, sh_gen[a], '1, 0);
        issue_good(OP_ACQUIRE, a, 0);
        issue_good(OP_ACQUIRE, a, 1);
        issue_good(OP_RELEASE, a, 0);
        issue_good(OP_RELEASE, a, 0);
        issue(OP_ACQUIRE, a, 0, sh_pool, 1);
        issue(OP_RELEASE, a, sh_gen[a], 0, 1);
        issue_good(OP_RELEASE, a, 1);
        issue_good(OP_FREE, a, 0);
        issue_good(OP_FREE, b, 0);
        issue_good(OP_FREE, b, 0);
        issue_good(OP_INCREF, b, 0);
        issue_good(OP_HANDLE, b, 0);
        issue_good(OP_QUERY, BLOCK_TOTAL - 1, 0);
        issue(OP_CHECK, BLOCK_TOTAL - 1, 0, sh_pool, 0);
        issue_good(OP_ACQUIRE, b, 1);
        issue(OP_ALLOC, 5, 0, 0, 0);

        // Wait for the clearing pass and the directed words to finish.
        drain();

        // Hold the receiver off while the sender keeps offering words.
        for (i = 0; i < 20; i++)
            issue_random();
        @(posedge clk);
        hold_go <= 1'b1;
        @(posedge clk);
        hold_go <= 1'b0;

        // Random phases over several pool tags, the extremes among them.
        pools[0] = 16'h0000;
        pools[1] = 16'hFFFF;
        pools[2] = POOL_W'($urandom());
        pools[3] = 16'h0001;
        pools[4] = POOL_W'($urandom());
        for (p = 0; p < 5; p++)
        begin
            write_pool(pools[p]);
            no_idle <= (p == 2);
            for (i = 0; i < 60; i++)
                issue_random();
        end

        // Exhaust the free queue, then give some blocks back.
        drain();
        no_idle <= 1'b0;
        for (i = 0; i < BLOCK_TOTAL + 4; i++)
            issue(OP_ALLOC, 0, 0, 0, 0);
        for (i = 0; i < 120 && live_ids.size() > 0; i++)
        begin
            a = live_ids[0];
            if (sh_cpin[a] > 0)
                issue_good(OP_RELEASE, a, 0);
            else if (sh_ipin[a] > 0)
                issue_good(OP_RELEASE, a, 1);
            else
                issue_good(OP_FREE, a, 0);
        end
        for (i = 0; i < 50; i++)
            issue_random();

        drain();
        repeat (20) @(posedge clk);
        $display("Checked %0d result words over 5 pool tags, queue exhaustion included.",
                 words_checked);
        $display("Status counts: ok %0d, empty %0d, free %0d, stale %0d, nopin %0d.",
                 status_seen[0], status_seen[1], status_seen[2], status_seen[3],
                 status_seen[4]);
        if (failures == 0 && expected_results.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end
endmodule

FILE: refcounted_block_allocator.f
+incdir+design
design/rcba_pkg.sv
design/rcba_free_queue.sv
design/refcounted_block_allocator.sv
design/rcba_checker.sv
test/refcounted_block_allocator_test.sv
